FILE: sv/battery_voltage_soc_estimator_defines.svh
// Assertion macros for the battery voltage state-of-charge estimator.
// Used by the port checker; needs nothing else.
`ifndef BATTERY_VOLTAGE_SOC_ESTIMATOR_DEFINES_SVH
`define BATTERY_VOLTAGE_SOC_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BVSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvse assertion failed");

// Next-cycle implication, disabled during reset.
`define BVSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvse assertion failed");

`endif

FILE: sv/bvse_pkg.sv
// Shared types and constants of the battery voltage state-of-charge estimator.
// Used by the divider, the top level, the port checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package bvse_pkg;

    localparam int AVG_DEPTH = 32;
    localparam int SLOT_W    = $clog2(AVG_DEPTH);
    localparam int COUNT_W   = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W     = 16 + $clog2(AVG_DEPTH);

    localparam int DIVD_W = 26;
    localparam int DIVS_W = 16;
    localparam int ITER_W = $clog2(DIVD_W + 1);
    localparam int MUL_W  = 26;

    localparam int SOC_STEPS = 26;

    localparam logic [10:0] GAIN_MAX   = 11'd1024;
    localparam logic [9:0]  SOC_MAX    = 10'd1000;
    localparam logic [9:0]  SOC_SCALE  = 10'd1000;
    localparam logic [23:0] FLT_MAX    = 24'hFFFFFF;

    // offset target: floor(p * 256 / 1000) = 32 * floor(p / 125) + floor(32 * rem / 125)
    localparam logic [6:0]  OFS_DIV    = 7'd125;
    localparam logic [25:0] OFS_RCP    = 26'd34359739;
    localparam logic [12:0] REM_RCP    = 13'd4195;

    localparam logic [12:0] RST_THRESH = 13'd80;
    localparam logic [9:0]  RST_RES    = 10'd125;
    localparam logic [9:0]  RST_SURF   = 10'd40;
    localparam logic [10:0] RST_GAIN   = 11'd61;
    localparam logic [15:0] RST_EMPTY  = 16'd6000;
    localparam logic [15:0] RST_FULL   = 16'd7300;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH = 3'd0,
        CFG_RES    = 3'd1,
        CFG_SURF   = 3'd2,
        CFG_GAIN   = 3'd3,
        CFG_EMPTY  = 3'd4,
        CFG_FULL   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        battery_mv;
        logic               battery_mv_valid;
        logic signed [15:0] battery_ma;
        logic               battery_ma_valid;
        logic               power_good;
        logic               charge_enabled;
    } t_in_item;

    typedef struct packed {
        logic [15:0] display_mv;
        logic        display_valid;
        logic [9:0]  charge_tenths_pct;
        logic        reported_power_good;
        logic        is_charging;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
        logic [ITER_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_AVG_GO,
        S_AVG_WAIT,
        S_OFS_MUL,
        S_OFS_RCP,
        S_OFS_REM,
        S_OFS_ADD,
        S_FLT_MUL,
        S_FLT_UPD,
        S_DISP,
        S_SOC_MUL,
        S_SOC_GO,
        S_SOC_WAIT,
        S_DONE
    } t_state;

endpackage

FILE: sv/bvse_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the voltage sample ring; depends on nothing.
`timescale 1ns / 1ps

module bvse_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bvse_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by the average and the
// charge ratio. Depends on bvse_pkg.
`timescale 1ns / 1ps

module bvse_div
    import bvse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   shifted;
    logic [DIVS_W+1:0] trial;
    logic              qbit;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dvs};
    assign qbit    = !trial[DIVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend << (ITER_W'(DIVD_W) - i_req.steps);
        end else if (r_busy) begin
            r_rem <= qbit ? trial[DIVS_W-1:0] : shifted[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], qbit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: sv/battery_voltage_soc_estimator.sv
// Each input beat is processed in turn: a valid voltage sample enters the ring and the sum is
// averaged by the shared divider (21 quotient bits); the charging offset target and filter are
// updated; the display voltage is formed; the charge ratio is divided (26 quotient bits) if the
// display voltage lies strictly inside a valid span. One item at a time; the next input beat
// is taken the cycle after the result is loaded into the output register. Reset (synchronous,
// active low) clears the average, filter and registers to defaults; the RAM needs no clearing.
`timescale 1ns / 1ps

module battery_voltage_soc_estimator
    import bvse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [12:0] r_thresh;
    logic [9:0]  r_mohm;
    logic [9:0]  r_surf;
    logic [10:0] r_gain;
    logic [15:0] r_empty;
    logic [15:0] r_vfull;

    t_in_item           r_item;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_full;
    logic [SUM_W-1:0]   r_sum;
    logic [15:0]        r_avg;
    logic               r_avg_valid;
    logic [23:0]        r_filter;
    logic [23:0]        r_target;
    logic [MUL_W-1:0]   r_mul;
    logic [18:0]        r_ofs_q;
    logic [6:0]         r_ofs_rem;
    logic signed [36:0] r_fprod;
    logic [15:0]        r_disp;
    logic [9:0]         r_soc;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic              ram_we;
    logic [15:0]       ram_rdata;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic              above;
    logic              charging;
    logic              out_free;
    logic [SUM_W-1:0]  sum_next;
    logic [SLOT_W-1:0] slot_next;
    logic [COUNT_W-1:0] avg_count;
    logic [MUL_W-1:0]  ofs_prod;
    logic [50:0]       ofs_qprod;
    logic [24:0]       rem_prod;
    logic [MUL_W-1:0]  soc_prod;
    logic [10:0]       gain_eff;
    logic signed [24:0] flt_diff;
    logic signed [36:0] flt_step;
    logic signed [37:0] flt_sum;
    logic [23:0]       flt_next;
    logic [24:0]       off_round;
    logic [16:0]       off_mv;
    logic [15:0]       disp_next;
    logic              range_ok;
    logic              soc_divide;

    bvse_ram #(
        .DEPTH (AVG_DEPTH),
        .WIDTH (16)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_item.battery_mv),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    bvse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign above    = r_item.battery_ma_valid &&
                      (r_item.battery_ma > $signed({3'b000, r_thresh}));
    assign charging = r_item.power_good && r_item.charge_enabled && above;
    assign out_free = !r_out_valid || i_out_ready;

    assign sum_next  = r_sum - (r_full ? SUM_W'(ram_rdata) : '0) + SUM_W'(r_item.battery_mv);
    assign slot_next = (r_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign avg_count = r_full ? COUNT_W'(AVG_DEPTH) : COUNT_W'(r_slot);

    assign ofs_prod  = MUL_W'(r_item.battery_ma[14:0]) * MUL_W'(r_mohm);
    assign ofs_qprod = 51'(r_mul[24:0]) * 51'(OFS_RCP);
    assign rem_prod  = 25'({r_ofs_rem, 5'd0}) * 25'(REM_RCP);
    assign soc_prod  = MUL_W'(r_disp - r_empty) * MUL_W'(SOC_SCALE);

    assign gain_eff = (r_gain > GAIN_MAX) ? GAIN_MAX : r_gain;
    assign flt_diff = $signed({1'b0, r_target}) - $signed({1'b0, r_filter});
    assign flt_step = r_fprod[36] ? ((r_fprod + 37'sd1023) >>> 10) : (r_fprod >>> 10);
    assign flt_sum  = $signed({14'd0, r_filter}) + 38'(flt_step);
    assign flt_next = flt_sum[37] ? 24'd0 :
                      (flt_sum > $signed({14'd0, FLT_MAX})) ? FLT_MAX : flt_sum[23:0];

    assign off_round = {1'b0, r_filter} + 25'd128;
    assign off_mv    = off_round[24:8];
    assign disp_next = ({1'b0, r_avg} > off_mv) ? (r_avg - off_mv[15:0]) : 16'd0;

    assign range_ok   = r_vfull > r_empty;
    assign soc_divide = range_ok && (r_disp > r_empty) && (r_disp < r_vfull);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_data.battery_mv_valid ? S_READ : S_OFS_MUL;
                end
            end
            S_READ:     n_state = S_SUM;
            S_SUM:      n_state = S_AVG_GO;
            S_AVG_GO:   n_state = S_AVG_WAIT;
            S_AVG_WAIT: n_state = div_rsp.done ? S_OFS_MUL : S_AVG_WAIT;
            S_OFS_MUL:  n_state = charging ? S_OFS_RCP : S_FLT_MUL;
            S_OFS_RCP:  n_state = S_OFS_REM;
            S_OFS_REM:  n_state = S_OFS_ADD;
            S_OFS_ADD:  n_state = S_FLT_MUL;
            S_FLT_MUL:  n_state = S_FLT_UPD;
            S_FLT_UPD:  n_state = S_DISP;
            S_DISP:     n_state = r_avg_valid ? S_SOC_MUL : S_DONE;
            S_SOC_MUL:  n_state = soc_divide ? S_SOC_GO : S_DONE;
            S_SOC_GO:   n_state = S_SOC_WAIT;
            S_SOC_WAIT: n_state = div_rsp.done ? S_DONE : S_SOC_WAIT;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        div_req    = '0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_SUM:  ram_we     = 1'b1;
            S_AVG_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'(r_sum);
                div_req.divisor  = DIVS_W'(avg_count);
                div_req.steps    = ITER_W'(SUM_W);
            end
            S_SOC_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'(r_mul);
                div_req.divisor  = r_vfull - r_empty;
                div_req.steps    = ITER_W'(SOC_STEPS);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_avg_valid <= 1'b0;
            r_filter    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SUM) begin
                r_sum  <= sum_next;
                r_slot <= slot_next;
                if (r_slot == SLOT_W'(AVG_DEPTH - 1)) begin
                    r_full <= 1'b1;
                end
            end
            if (r_state == S_AVG_WAIT && div_rsp.done) begin
                r_avg       <= div_rsp.quotient[15:0];
                r_avg_valid <= 1'b1;
            end
            if (r_state == S_FLT_UPD) begin
                r_filter <= flt_next;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (r_state == S_OFS_MUL) begin
            r_mul    <= ofs_prod;
            r_target <= '0;
        end
        if (r_state == S_OFS_RCP) begin
            r_ofs_q <= ofs_qprod[50:32];
        end
        if (r_state == S_OFS_REM) begin
            r_ofs_rem <= 7'(r_mul[24:0] - 25'(r_ofs_q) * 25'(OFS_DIV));
        end
        if (r_state == S_OFS_ADD) begin
            r_target <= {r_ofs_q, 5'd0} + 24'(rem_prod[24:19]) + {6'd0, r_surf, 8'd0};
        end
        if (r_state == S_FLT_MUL) begin
            r_fprod <= flt_diff * $signed({1'b0, gain_eff});
        end
        if (r_state == S_DISP) begin
            r_disp <= r_avg_valid ? disp_next : 16'd0;
            r_soc  <= '0;
        end
        if (r_state == S_SOC_MUL) begin
            r_mul <= soc_prod;
            r_soc <= (range_ok && r_disp >= r_vfull) ? SOC_MAX : 10'd0;
        end
        if (r_state == S_SOC_WAIT && div_rsp.done) begin
            r_soc <= div_rsp.quotient[9:0];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data.display_mv          <= r_disp;
            r_out_data.display_valid       <= r_avg_valid;
            r_out_data.charge_tenths_pct   <= r_soc;
            r_out_data.reported_power_good <= r_item.power_good;
            r_out_data.is_charging         <= r_item.power_good && above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= RST_THRESH;
            r_mohm   <= RST_RES;
            r_surf   <= RST_SURF;
            r_gain   <= RST_GAIN;
            r_empty  <= RST_EMPTY;
            r_vfull  <= RST_FULL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESH: r_thresh <= i_cfg_data[12:0];
                CFG_RES:    r_mohm   <= i_cfg_data[9:0];
                CFG_SURF:   r_surf   <= i_cfg_data[9:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[10:0];
                CFG_EMPTY:  r_empty  <= i_cfg_data;
                CFG_FULL:   r_vfull  <= i_cfg_data;
                default: begin
                    r_thresh <= r_thresh;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/bvse_chk.sv
// Port checker for the battery voltage state-of-charge estimator, bound to the top level.
// Depends on bvse_pkg and battery_voltage_soc_estimator_defines.svh.
`timescale 1ns / 1ps
`include "battery_voltage_soc_estimator_defines.svh"

module bvse_chk
    import bvse_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_data
);

    `BVSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                      o_out_valid && $stable(o_out_data))
    `BVSE_ASSERT_IMPL(a_soc_range, i_clk, i_rst_n, o_out_valid,
                      o_out_data.charge_tenths_pct <= SOC_MAX)
    `BVSE_ASSERT_IMPL(a_no_avg_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.display_valid,
                      o_out_data.display_mv == 16'd0 && o_out_data.charge_tenths_pct == 10'd0)
    `BVSE_ASSERT_IMPL(a_chg_pg, i_clk, i_rst_n, o_out_valid && o_out_data.is_charging,
                      o_out_data.reported_power_good)
    `BVSE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind battery_voltage_soc_estimator bvse_chk u_bvse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/sv/battery_voltage_soc_estimator_test.sv
// Self-checking testbench for battery_voltage_soc_estimator: a tracker class predicts each
// result beat from the accepted update beats and register writes; plain tasks drive the block.
// Depends on bvse_pkg and the estimator RTL.
`timescale 1ns / 1ps

module battery_voltage_soc_estimator_test;
    import bvse_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [1:0] READY_ALWAYS = 2'd0;
    localparam logic [1:0] READY_SPARSE = 2'd1;
    localparam logic [1:0] READY_BLOCKS = 2'd2;
    localparam logic [1:0] READY_COIN   = 2'd3;

    class soc_estimate_tracker;
        logic [15:0] sample_ring [AVG_DEPTH];
        int unsigned write_slot;
        bit          ring_full;
        longint      running_sum;
        longint      average_mv;
        bit          average_valid;
        longint      offset_q8;
        longint      thresh_ma, res_mohm, surf_mv, gain_q10, empty_mv, full_mv;
        t_out_item   pending_reports [$];
        int          mismatches;
        int          checked;
        int          charging_reports;
        int          mid_scale_reports;
        int          full_scale_reports;

        function new();
            write_slot    = 0;
            ring_full     = 0;
            running_sum   = 0;
            average_mv    = 0;
            average_valid = 0;
            offset_q8     = 0;
            thresh_ma     = RST_THRESH;
            res_mohm      = RST_RES;
            surf_mv       = RST_SURF;
            gain_q10      = RST_GAIN;
            empty_mv      = RST_EMPTY;
            full_mv       = RST_FULL;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                CFG_THRESH: thresh_ma = value[12:0];
                CFG_RES:    res_mohm  = value[9:0];
                CFG_SURF:   surf_mv   = value[9:0];
                CFG_GAIN:   gain_q10  = value[10:0];
                CFG_EMPTY:  empty_mv  = value;
                CFG_FULL:   full_mv   = value;
                default: ;
            endcase
        endfunction

        function void note_update(t_in_item it);
            int          ma;
            bit          above;
            int unsigned slot;
            longint      gain, target, step, filtered, off, disp, soc;
            t_out_item   r;
            ma    = int'($signed(it.battery_ma));
            above = it.battery_ma_valid && (longint'(ma) > thresh_ma);

            if (it.battery_mv_valid) begin
                slot = write_slot;
                if (ring_full)
                    running_sum = running_sum - longint'(sample_ring[slot]);
                sample_ring[slot] = it.battery_mv;
                running_sum = running_sum + longint'(it.battery_mv);
                slot++;
                if (slot >= AVG_DEPTH) begin
                    slot = 0;
                    ring_full = 1;
                end
                write_slot    = slot;
                average_mv    = running_sum / (ring_full ? longint'(AVG_DEPTH) : longint'(slot));
                average_valid = 1;
            end

            // first-order offset filter, step truncated toward zero
            gain   = (gain_q10 > longint'(GAIN_MAX)) ? longint'(GAIN_MAX) : gain_q10;
            target = 0;
            if (it.power_good && it.charge_enabled && above && ma > 0)
                target = (longint'(ma) * res_mohm * 256) / 1000 + surf_mv * 256;
            step     = ((target - offset_q8) * gain) / 1024;
            filtered = offset_q8 + step;
            if (filtered < 0)
                filtered = 0;
            if (filtered > longint'(FLT_MAX))
                filtered = longint'(FLT_MAX);
            offset_q8 = filtered;

            disp = 0;
            soc  = 0;
            if (average_valid) begin
                off  = (offset_q8 + 128) >> 8;
                disp = (average_mv > off) ? average_mv - off : 0;
                if (full_mv > empty_mv) begin
                    if (disp <= empty_mv)
                        soc = 0;
                    else if (disp >= full_mv)
                        soc = 1000;
                    else
                        soc = ((disp - empty_mv) * 1000) / (full_mv - empty_mv);
                end
            end

            r.display_mv          = disp[15:0];
            r.display_valid       = average_valid;
            r.charge_tenths_pct   = soc[9:0];
            r.reported_power_good = it.power_good;
            r.is_charging         = it.power_good && above;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with nothing pending, display_mv actual %0d",
                         $time, got.display_mv);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            if (want.is_charging)
                charging_reports++;
            if (want.charge_tenths_pct == SOC_MAX)
                full_scale_reports++;
            else if (want.charge_tenths_pct != 0)
                mid_scale_reports++;
            compare_field("display_mv", want.display_mv, got.display_mv);
            compare_field("display_valid", 16'(want.display_valid), 16'(got.display_valid));
            compare_field("charge_tenths_pct", 16'(want.charge_tenths_pct),
                          16'(got.charge_tenths_pct));
            compare_field("reported_power_good", 16'(want.reported_power_good),
                          16'(got.reported_power_good));
            compare_field("is_charging", 16'(want.is_charging), 16'(got.is_charging));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    soc_estimate_tracker tracker = new();
    int                  updates_sent = 0;
    int                  registers_written = 0;
    logic [7:0]          ready_tick = '0;
    logic [1:0]          ready_mode = READY_ALWAYS;

    battery_voltage_soc_estimator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: switch stall pattern each time the 8-bit tick counter wraps
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 8'd1;
        if (ready_tick == 8'd0)
            ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            READY_BLOCKS: i_out_ready <= ready_tick[4];
            default:      i_out_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            tracker.check_report(o_out_data);
    end

    function automatic t_in_item make_update(logic [15:0] mv, logic mv_ok, logic [15:0] ma,
                                             logic ma_ok, logic pg, logic en);
        t_in_item it;
        it.battery_mv       = mv;
        it.battery_mv_valid = mv_ok;
        it.battery_ma       = ma;
        it.battery_ma_valid = ma_ok;
        it.power_good       = pg;
        it.charge_enabled   = en;
        return it;
    endfunction

    // mostly voltages around the empty..full span and moderate currents, some noise
    function automatic t_in_item rand_update();
        t_in_item    it;
        int unsigned lo, hi, pick;
        lo = (tracker.empty_mv < tracker.full_mv) ? 32'(tracker.empty_mv) : 32'(tracker.full_mv);
        hi = (tracker.empty_mv < tracker.full_mv) ? 32'(tracker.full_mv) : 32'(tracker.empty_mv);
        lo = (lo > 400) ? lo - 400 : 0;
        hi = (hi < 65135) ? hi + 400 : 65535;
        if ($urandom_range(0, 9) < 7)
            it.battery_mv = 16'($urandom_range(lo, hi));
        else
            it.battery_mv = 16'($urandom());
        pick = $urandom_range(0, 9);
        if (pick < 6)
            it.battery_ma = 16'($urandom_range(0, 3500) - 500);
        else if (pick == 6)
            it.battery_ma = 16'(tracker.thresh_ma + $urandom_range(0, 4) - 2);
        else
            it.battery_ma = 16'($urandom());
        it.battery_mv_valid = ($urandom_range(0, 9) != 0);
        it.battery_ma_valid = ($urandom_range(0, 9) != 0);
        it.power_good       = ($urandom_range(0, 4) != 0);
        it.charge_enabled   = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic wait_drained();
        while (tracker.pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_update(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_update(it);
        updates_sent++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_register(idx, value);
        registers_written++;
    endtask

    // bursts of beats with random gaps; now and then hold until all results are back
    task automatic run_random(int count);
        int left, burst, gap;
        bit drain;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            repeat (burst) send_update(rand_update());
            left  = left - burst;
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            drain = ($urandom_range(0, 24) == 0);
            if (gap > 0 || drain || left == 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if (drain)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        t_in_item opening [$];
        opening.push_back(make_update(16'hFFFF, 1'b0, 16'd500, 1'b1, 1'b1, 1'b1));
        opening.push_back(make_update(16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
        opening.push_back(make_update(16'd7000, 1'b1, 16'd80, 1'b1, 1'b1, 1'b1));
        opening.push_back(make_update(16'd7000, 1'b1, 16'd81, 1'b1, 1'b1, 1'b1));
        opening.push_back(make_update(16'd7000, 1'b1, 16'd2000, 1'b1, 1'b1, 1'b0));
        opening.push_back(make_update(16'd7000, 1'b1, 16'd2000, 1'b0, 1'b1, 1'b1));
        opening.push_back(make_update(16'd7000, 1'b1, 16'h8000, 1'b1, 1'b1, 1'b1));
        opening.push_back(make_update(16'd7000, 1'b1, 16'h7FFF, 1'b1, 1'b1, 1'b1));
        opening.push_back(make_update(16'd7000, 1'b1, 16'h7FFF, 1'b1, 1'b0, 1'b1));
        opening.push_back(make_update(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0));
        opening.push_back(make_update(16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0));
        opening.push_back(make_update(16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0));
        opening.push_back(make_update(16'd7300, 1'b0, 16'd3000, 1'b1, 1'b1, 1'b1));
        opening.push_back(make_update(16'd6000, 1'b1, 16'd0, 1'b0, 1'b1, 1'b1));
        opening.push_back(make_update(16'd5000, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1));
        opening.push_back(make_update(16'd6650, 1'b1, 16'd1500, 1'b1, 1'b1, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k])
            send_update(opening[k]);
        i_in_valid <= 1'b0;
        wait_drained();
        run_random(40);

        write_register(CFG_THRESH, 16'd0);
        write_register(CFG_RES, 16'd1000);
        write_register(CFG_SURF, 16'd1000);
        write_register(CFG_GAIN, 16'd1024);
        write_register(CFG_EMPTY, 16'd0);
        write_register(CFG_FULL, 16'd65535);
        i_cfg_valid <= 1'b0;
        run_random(70);

        write_register(CFG_THRESH, 16'd5000);
        write_register(CFG_RES, 16'd0);
        write_register(CFG_SURF, 16'd0);
        write_register(CFG_GAIN, 16'd1);
        write_register(CFG_EMPTY, 16'd7000);
        write_register(CFG_FULL, 16'd7000);
        i_cfg_valid <= 1'b0;
        run_random(60);

        // masked values, frozen filter, inverted span, writes to unused indexes
        write_register(CFG_THRESH, 16'hFFFF);
        write_register(CFG_RES, 16'hFFFF);
        write_register(CFG_SURF, 16'hFFFF);
        write_register(CFG_GAIN, 16'd0);
        write_register(CFG_EMPTY, 16'd9000);
        write_register(CFG_FULL, 16'd3000);
        write_register(CFG_SPARE_LO, 16'h1234);
        write_register(CFG_SPARE_HI, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        run_random(60);

        write_register(CFG_THRESH, 16'd200);
        write_register(CFG_RES, 16'd300);
        write_register(CFG_SURF, 16'hFC00);
        write_register(CFG_GAIN, 16'hFFFF);
        write_register(CFG_EMPTY, 16'd3000);
        write_register(CFG_FULL, 16'd4200);
        i_cfg_valid <= 1'b0;
        run_random(70);

        write_register(CFG_THRESH, 16'(RST_THRESH));
        write_register(CFG_RES, 16'd500);
        write_register(CFG_SURF, 16'(RST_SURF));
        write_register(CFG_GAIN, 16'd200);
        write_register(CFG_EMPTY, RST_EMPTY);
        write_register(CFG_FULL, RST_FULL);
        i_cfg_valid <= 1'b0;
        run_random(110);
        run_random(110);

        wait_drained();
        repeat (120) @(posedge i_clk);
        $display("Sent %0d updates and %0d register writes over six register settings.",
                 updates_sent, registers_written);
        $display("Checked %0d results: %0d charging, %0d mid-scale, %0d at full charge.",
                 tracker.checked, tracker.charging_reports, tracker.mid_scale_reports,
                 tracker.full_scale_reports);
        if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t: timed out with %0d results outstanding", $time,
                 tracker.pending_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/bvse_pkg.sv
sv/bvse_ram.sv
sv/bvse_div.sv
sv/battery_voltage_soc_estimator.sv
sv/bvse_chk.sv
tb/sv/battery_voltage_soc_estimator_test.sv
